/* hw/rtl/spl_pkg.sv */
`default_nettype none

package spl_pkg;

	localparam int COORD_BITS_DEF = 14;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPLIT_MODE   = 2'd2;

	// two-seat split modes; the unused code behaves as auto
	localparam int MODE_BITS = 2;
	localparam logic [MODE_BITS-1:0] MODE_AUTO  = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_SIDE  = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_STACK = 2'd2;

	localparam int FRAME_WIDTH_RST  = 1920;
	localparam int FRAME_HEIGHT_RST = 1080;

	localparam int SEAT_BITS  = 4;
	localparam int COUNT_BITS = 3;
	localparam int INDEX_BITS = 2;
	localparam logic [COUNT_BITS-1:0] MAX_PANES = 3'd4;

endpackage

`default_nettype wire

/* hw/rtl/split_screen_pane_layout.sv */
// Pipeline: 4 register stages (s1..s3, emit); a request passes s1, s2 and s3 and then
//   loads the emit stage, whose outputs then carry its first pane.
// Throughput: one pane per cycle while pane_stall is low; a request holds the emit stage
//   until its last pane transfers, so the request rate is set by the single emit stage.
// Reset (arst_n low, async): pipeline empty, pane counter cleared, registers back to
//   1920 x 1080, auto split.
`default_nettype none

module split_screen_pane_layout #(
	parameter int COORD_BITS = spl_pkg::COORD_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [spl_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [COORD_BITS-1:0]           cfg_data,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire logic [spl_pkg::SEAT_BITS-1:0]   seat_count,
	output logic                                 pane_valid,
	input  wire logic                            pane_stall,
	output logic [spl_pkg::INDEX_BITS-1:0]       pane_index,
	output logic [COORD_BITS-1:0]                pane_x,
	output logic [COORD_BITS-1:0]                pane_y,
	output logic [COORD_BITS-1:0]                pane_width,
	output logic [COORD_BITS-1:0]                pane_height,
	output logic [spl_pkg::COUNT_BITS-1:0]       pane_count,
	output logic                                 last_pane
);
	import spl_pkg::*;

	logic [COORD_BITS-1:0] frame_width_q, frame_height_q;
	logic [MODE_BITS-1:0]  split_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= COORD_BITS'(FRAME_WIDTH_RST);
			frame_height_q <= COORD_BITS'(FRAME_HEIGHT_RST);
			split_mode_q   <= MODE_AUTO;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_SPLIT_MODE:   split_mode_q   <= cfg_data[MODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic                  en;
	logic                  valid_s3, side_s3;
	logic [COUNT_BITS-1:0] count_s3;
	logic [COORD_BITS-1:0] width_s3, height_s3;

	spl_aspect #(
		.COORD_BITS(COORD_BITS)
	) u_aspect (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid       (req_valid),
		.seat_count  (seat_count),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.split_mode  (split_mode_q),
		.valid_s3    (valid_s3),
		.count_s3    (count_s3),
		.side_s3     (side_s3),
		.width_s3    (width_s3),
		.height_s3   (height_s3)
	);

	// s4: emit stage, walks the panes of one layout
	logic                  valid_s4, side_s4;
	logic [COUNT_BITS-1:0] count_s4;
	logic [COORD_BITS-1:0] width_s4, height_s4;
	logic [INDEX_BITS-1:0] idx_q;
	logic                  pane_xfer;

	assign pane_xfer = pane_valid && !pane_stall;
	assign en        = !valid_s4 || (pane_xfer && last_pane);
	assign req_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			idx_q    <= '0;
		end else if (en) begin
			valid_s4 <= valid_s3;
			idx_q    <= '0;
		end else if (pane_xfer) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			count_s4  <= count_s3;
			side_s4   <= side_s3;
			width_s4  <= width_s3;
			height_s4 <= height_s3;
		end
	end

	logic [COORD_BITS-1:0] hw, hh;
	assign hw = width_s4 >> 1;
	assign hh = height_s4 >> 1;

	always_comb begin
		pane_valid  = valid_s4;
		pane_index  = idx_q;
		pane_count  = count_s4;
		pane_x      = '0;
		pane_y      = '0;
		pane_width  = hw;
		pane_height = hh;
		last_pane   = 1'b0;
		case (count_s4)
			3'd0: begin
				pane_width  = '0;
				pane_height = '0;
				last_pane   = 1'b1;
			end
			3'd1: begin
				pane_width  = width_s4;
				pane_height = height_s4;
				last_pane   = 1'b1;
			end
			3'd2: begin
				last_pane = idx_q[0];
				if (side_s4) begin
					pane_x      = idx_q[0] ? hw : '0;
					pane_height = height_s4;
				end else begin
					pane_y     = idx_q[0] ? hh : '0;
					pane_width = width_s4;
				end
			end
			default: begin
				// quadrants; with three seats bottom-right is skipped
				pane_x    = idx_q[0] ? hw : '0;
				pane_y    = idx_q[1] ? hh : '0;
				last_pane = ({1'b0, idx_q} == count_s4 - 3'd1);
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/spl_aspect.sv */
`default_nettype none

module spl_aspect #(
	parameter int COORD_BITS = spl_pkg::COORD_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             valid,
	input  wire logic [spl_pkg::SEAT_BITS-1:0]    seat_count,
	input  wire logic [COORD_BITS-1:0]            frame_width,
	input  wire logic [COORD_BITS-1:0]            frame_height,
	input  wire logic [spl_pkg::MODE_BITS-1:0]    split_mode,
	output logic                                  valid_s3,
	output logic [spl_pkg::COUNT_BITS-1:0]        count_s3,
	output logic                                  side_s3,
	output logic [COORD_BITS-1:0]                 width_s3,
	output logic [COORD_BITS-1:0]                 height_s3
);
	import spl_pkg::*;

	localparam int EW = COORD_BITS + 4;   // holds 9*W and 16*H
	localparam int PW = EW + COORD_BITS;  // product width

	logic [COORD_BITS-1:0] hw, hh;
	logic [EW-1:0]         nine_w, nine_hw, sixteen_h, sixteen_hh;
	logic [EW-1:0]         diff_a, diff_b;
	logic [COUNT_BITS-1:0] count_c;

	assign hw         = frame_width >> 1;
	assign hh         = frame_height >> 1;
	assign nine_w     = (EW'(frame_width) << 3) + EW'(frame_width);
	assign nine_hw    = (EW'(hw) << 3) + EW'(hw);
	assign sixteen_h  = EW'(frame_height) << 4;
	assign sixteen_hh = EW'(hh) << 4;
	assign diff_a     = (nine_hw >= sixteen_h) ? nine_hw - sixteen_h : sixteen_h - nine_hw;
	assign diff_b     = (nine_w >= sixteen_hh) ? nine_w - sixteen_hh : sixteen_hh - nine_w;
	assign count_c    = (seat_count > SEAT_BITS'(MAX_PANES)) ? MAX_PANES
	                                                          : COUNT_BITS'(seat_count);

	// s1: aspect distances
	logic                  valid_s1, force_side_s1, force_stack_s1;
	logic [COUNT_BITS-1:0] count_s1;
	logic [EW-1:0]         diff_a_s1, diff_b_s1;
	logic [COORD_BITS-1:0] width_s1, height_s1;

	// s2: cross products
	logic                  valid_s2, force_side_s2, force_stack_s2, hh_zero_s2;
	logic [COUNT_BITS-1:0] count_s2;
	logic [PW-1:0]         prod_a_s2, prod_b_s2;
	logic [COORD_BITS-1:0] width_s2, height_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			count_s1       <= count_c;
			force_side_s1  <= (split_mode == MODE_SIDE);
			force_stack_s1 <= (split_mode == MODE_STACK);
			diff_a_s1      <= diff_a;
			diff_b_s1      <= diff_b;
			width_s1       <= frame_width;
			height_s1      <= frame_height;

			count_s2       <= count_s1;
			force_side_s2  <= force_side_s1;
			force_stack_s2 <= force_stack_s1;
			hh_zero_s2     <= ((height_s1 >> 1) == '0);
			prod_a_s2      <= PW'(diff_a_s1) * PW'(height_s1 >> 1);
			prod_b_s2      <= PW'(diff_b_s1) * PW'(height_s1);
			width_s2       <= width_s1;
			height_s2      <= height_s1;

			// tie goes to side by side
			count_s3  <= count_s2;
			side_s3   <= force_side_s2 ||
			             (!force_stack_s2 && (hh_zero_s2 || prod_a_s2 <= prod_b_s2));
			width_s3  <= width_s2;
			height_s3 <= height_s2;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/spl_checker.sv */
`default_nettype none

module spl_checker #(
	parameter int COORD_BITS = spl_pkg::COORD_BITS_DEF
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            pane_valid,
	input wire logic                            pane_stall,
	input wire logic [spl_pkg::INDEX_BITS-1:0]  pane_index,
	input wire logic [COORD_BITS-1:0]           pane_x,
	input wire logic [COORD_BITS-1:0]           pane_y,
	input wire logic [spl_pkg::COUNT_BITS-1:0]  pane_count,
	input wire logic                            last_pane
);
	import spl_pkg::*;

	// a stalled pane holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pane_valid && pane_stall |=> pane_valid && $stable(pane_index) &&
		$stable(pane_x) && $stable(pane_y) && $stable(pane_count) && $stable(last_pane))
		else $error("stalled pane changed");

	// empty layout is a single terminal item
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pane_valid && pane_count == 3'd0 |-> last_pane && pane_index == '0)
		else $error("empty layout malformed");

	// the last pane carries the final index of the layout
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		pane_valid && last_pane && pane_count != 3'd0 |->
		{1'b0, pane_index} == pane_count - 3'd1)
		else $error("last pane index mismatch");

	// panes of one layout follow back to back in index order
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		pane_valid && !pane_stall && !last_pane |=>
		pane_valid && pane_index == $past(pane_index) + 2'd1 &&
		pane_count == $past(pane_count))
		else $error("pane sequence broken");

endmodule

bind split_screen_pane_layout spl_checker #(
	.COORD_BITS(COORD_BITS)
) u_spl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pane_valid(pane_valid),
	.pane_stall(pane_stall),
	.pane_index(pane_index),
	.pane_x    (pane_x),
	.pane_y    (pane_y),
	.pane_count(pane_count),
	.last_pane (last_pane)
);

`default_nettype wire

/* test/tb_split_screen_pane_layout.sv */
`default_nettype none

module tb_split_screen_pane_layout;

	import spl_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam logic [CW-1:0] COORD_MAX = '1;
	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [INDEX_BITS-1:0] idx;
		logic [CW-1:0]         x;
		logic [CW-1:0]         y;
		logic [CW-1:0]         w;
		logic [CW-1:0]         h;
		logic [COUNT_BITS-1:0] count;
		logic                  last;
	} pane_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [SEAT_BITS-1:0] seat_count = '0;
	logic pane_valid;
	logic pane_stall = 1'b0;
	logic [INDEX_BITS-1:0] pane_index;
	logic [CW-1:0] pane_x, pane_y, pane_width, pane_height;
	logic [COUNT_BITS-1:0] pane_count;
	logic last_pane;

	// shadow of the layout registers
	logic [CW-1:0] frame_w = CW'(FRAME_WIDTH_RST);
	logic [CW-1:0] frame_h = CW'(FRAME_HEIGHT_RST);
	logic [MODE_BITS-1:0] split_sel = MODE_AUTO;

	pane_t pending_panes[$];
	pane_t got_pane, want_pane;

	int mismatches = 0;
	int requests_sent = 0;
	int panes_checked = 0;
	int cfg_writes = 0;
	int idle_cycles = 0;

	// receiver stall control
	int stall_style = 0;
	logic [7:0] stall_mask = 8'b1110_0100;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;
	int hold_len = 0;
	int hold_left = 0;

	split_screen_pane_layout dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.seat_count(seat_count),
		.pane_valid(pane_valid),
		.pane_stall(pane_stall),
		.pane_index(pane_index),
		.pane_x(pane_x),
		.pane_y(pane_y),
		.pane_width(pane_width),
		.pane_height(pane_height),
		.pane_count(pane_count),
		.last_pane(last_pane)
	);

	always #5 clk = ~clk;

	function automatic pane_t pane_rect(input int idx, input logic [CW-1:0] x, y, w, h,
			input int count, input bit last);
		pane_t p;
		p.idx = INDEX_BITS'(idx);
		p.x = x;
		p.y = y;
		p.w = w;
		p.h = h;
		p.count = COUNT_BITS'(count);
		p.last = last;
		return p;
	endfunction

	// auto split: side by side when its pane aspect is at least as close to 16:9
	function automatic bit side_by_side_wins();
		logic [63:0] w, h, hw, hh, d_side, d_stack;
		w = 64'(frame_w);
		h = 64'(frame_h);
		hw = w / 2;
		hh = h / 2;
		if (split_sel == MODE_SIDE)
			return 1'b1;
		if (split_sel == MODE_STACK)
			return 1'b0;
		if (hh == 0)
			return 1'b1;
		d_side = (9 * hw >= 16 * h) ? 9 * hw - 16 * h : 16 * h - 9 * hw;
		d_stack = (9 * w >= 16 * hh) ? 9 * w - 16 * hh : 16 * hh - 9 * w;
		return d_side * hh <= d_stack * h;
	endfunction

	task automatic predict_layout(input logic [SEAT_BITS-1:0] seats);
		logic [CW-1:0] hw, hh;
		int n;
		hw = frame_w >> 1;
		hh = frame_h >> 1;
		n = (seats > MAX_PANES) ? int'(MAX_PANES) : int'(seats);
		case (n)
			0: pending_panes.push_back(pane_rect(0, 0, 0, 0, 0, 0, 1'b1));
			1: pending_panes.push_back(pane_rect(0, 0, 0, frame_w, frame_h, 1, 1'b1));
			2: begin
				if (side_by_side_wins()) begin
					pending_panes.push_back(pane_rect(0, 0, 0, hw, frame_h, 2, 1'b0));
					pending_panes.push_back(pane_rect(1, hw, 0, hw, frame_h, 2, 1'b1));
				end else begin
					pending_panes.push_back(pane_rect(0, 0, 0, frame_w, hh, 2, 1'b0));
					pending_panes.push_back(pane_rect(1, 0, hh, frame_w, hh, 2, 1'b1));
				end
			end
			default: begin
				pending_panes.push_back(pane_rect(0, 0, 0, hw, hh, n, 1'b0));
				pending_panes.push_back(pane_rect(1, hw, 0, hw, hh, n, 1'b0));
				pending_panes.push_back(pane_rect(2, 0, hh, hw, hh, n, n == 3));
				if (n == 4)
					pending_panes.push_back(pane_rect(3, hw, hh, hw, hh, n, 1'b1));
			end
		endcase
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_request(input logic [SEAT_BITS-1:0] seats);
		req_valid <= 1'b1;
		seat_count <= seats;
		do
			@(posedge clk);
		while (req_stall);
		predict_layout(seats);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic pause_requests(input int cycles);
		if (cycles > 0) begin
			req_valid <= 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_FRAME_WIDTH: frame_w = data;
			REG_FRAME_HEIGHT: frame_h = data;
			REG_SPLIT_MODE: split_sel = data[MODE_BITS-1:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// wait until every expected pane is out, plus the pipeline depth
	task automatic drain();
		req_valid <= 1'b0;
		while (pending_panes.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic hold_receiver(input int cycles);
		hold_len = cycles;
		hold_req = ~hold_req;
	endtask

	task automatic set_frame(input logic [CW-1:0] w, h, mode_word);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_SPLIT_MODE, mode_word);
	endtask

	task automatic test_seat_counts();
		logic [SEAT_BITS-1:0] counts[8] = '{0, 1, 2, 3, 4, 5, 8, 15};
		foreach (counts[i])
			send_request(counts[i]);
		drain();
	endtask

	task automatic test_split_modes();
		// upper data bits must be dropped by the mode register
		write_reg(REG_SPLIT_MODE, 14'h3FFD);
		send_request(2);
		drain();
		write_reg(REG_SPLIT_MODE, 14'h3FFE);
		send_request(2);
		drain();
		write_reg(REG_SPLIT_MODE, 14'h3FFF);
		send_request(2);
		drain();
		write_reg(REG_UNUSED, 14'h2AAA);
		send_request(2);
		drain();
	endtask

	task automatic test_frame_extremes();
		set_frame(COORD_MAX, COORD_MAX, MODE_AUTO);
		send_request(2);
		send_request(4);
		drain();
		set_frame(0, 0, MODE_AUTO);
		send_request(1);
		send_request(2);
		send_request(3);
		drain();
		// half height of zero forces side by side
		set_frame(1920, 1, MODE_AUTO);
		send_request(2);
		drain();
		set_frame(1, COORD_MAX, MODE_AUTO);
		send_request(2);
		send_request(4);
		drain();
	endtask

	task automatic test_output_backpressure();
		set_frame(CW'($urandom_range(2, 8000)), CW'($urandom_range(2, 8000)), MODE_AUTO);
		stall_style = 0;
		hold_receiver(LONG_HOLD);
		for (int i = 0; i < 30; i++)
			send_request(SEAT_BITS'($urandom_range(0, 15)));
		drain();
	endtask

	task automatic test_random_traffic();
		int left, burst, max_gap;
		logic [CW-1:0] w, h;
		for (int phase = 0; phase < 6; phase++) begin
			case ($urandom_range(0, 3))
				0: begin
					w = CW'($urandom_range(0, 16383));
					h = CW'($urandom_range(0, 16383));
				end
				1: begin
					w = CW'($urandom_range(0, 7));
					h = CW'($urandom_range(0, 7));
				end
				2: begin
					w = CW'($urandom_range(1000, 4000));
					h = CW'($urandom_range(500, 3000));
				end
				default: begin
					w = ($urandom_range(0, 1) != 0) ? COORD_MAX : CW'($urandom_range(0, 1));
					h = ($urandom_range(0, 1) != 0) ? COORD_MAX : CW'($urandom_range(0, 1));
				end
			endcase
			set_frame(w, h, CW'($urandom_range(0, 16383)));
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_UNUSED, CW'($urandom_range(0, 16383)));
			stall_style = phase % 4;
			max_gap = (phase == 2) ? 0 : 6;
			left = 35;
			while (left > 0) begin
				burst = $urandom_range(1, 8);
				while (burst > 0 && left > 0) begin
					send_request(SEAT_BITS'($urandom_range(0, 15)));
					burst--;
					left--;
				end
				if (left > 0)
					pause_requests($urandom_range(0, max_gap));
			end
			drain();
		end
		stall_style = 0;
	endtask

	// receiver: long hold on request, otherwise its own stall pattern
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = hold_len;
		end
		stall_mask = {stall_mask[6:0], stall_mask[7] ^ stall_mask[3]};
		if (hold_left > 0) begin
			hold_left--;
			pane_stall <= 1'b1;
		end else begin
			case (stall_style)
				1: pane_stall <= ($urandom_range(0, 2) == 0);
				2: pane_stall <= stall_mask[0];
				3: pane_stall <= ($urandom_range(0, 2) != 0);
				default: pane_stall <= 1'b0;
			endcase
		end
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 10) begin
			$display("pane mismatch (%s) at %0t", what, $time);
			$display("  got  idx=%0d x=%0d y=%0d w=%0d h=%0d count=%0d last=%0d",
				got_pane.idx, got_pane.x, got_pane.y, got_pane.w, got_pane.h,
				got_pane.count, got_pane.last);
			$display("  want idx=%0d x=%0d y=%0d w=%0d h=%0d count=%0d last=%0d",
				want_pane.idx, want_pane.x, want_pane.y, want_pane.w, want_pane.h,
				want_pane.count, want_pane.last);
		end
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && pane_valid && !pane_stall) begin
			got_pane = {pane_index, pane_x, pane_y, pane_width, pane_height,
				pane_count, last_pane};
			if (pending_panes.size() == 0) begin
				want_pane = '0;
				report_mismatch("unexpected transfer");
			end else begin
				want_pane = pending_panes.pop_front();
				if (got_pane !== want_pane)
					report_mismatch("field value");
				panes_checked++;
			end
		end
	end

	// watchdog on cycles with no transfer on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (pane_valid && !pane_stall)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_seat_counts();
		test_split_modes();
		test_frame_extremes();
		test_output_backpressure();
		test_random_traffic();
		drain();
		repeat (10) @(negedge clk);
		$display("Ran %0d seat requests, checked %0d panes, %0d register writes;",
			requests_sent, panes_checked, cfg_writes);
		$display("all split modes, frame extremes, a long output hold and random stalls.");
		if (mismatches == 0 && pending_panes.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d panes still expected", mismatches,
				pending_panes.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
